// ===== rtl/byte_register_machine_execute_defines.svh =====
// Assertion macros for the byte register machine execute block.
// No dependencies.
`ifndef BYTE_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define BYTE_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
// implication checked on every rising clock edge, quiet in reset
`define BRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/brm_pkg.sv =====
// Shared types and codes for the byte register machine execute block.
// No dependencies.
`timescale 1ns / 1ps
package brm_pkg;
    localparam int DATA_W = 8;

    typedef enum logic [3:0] {
        CMD_IN = 4'd0, CMD_OUT = 4'd1, CMD_MOV = 4'd2, CMD_ADD = 4'd3,
        CMD_SUB = 4'd4, CMD_MUL = 4'd5, CMD_DIV = 4'd6, CMD_INC = 4'd7,
        CMD_DEC = 4'd8, CMD_ROL = 4'd9, CMD_ROR = 4'd10, CMD_SHL = 4'd11,
        CMD_SHR = 4'd12, CMD_LOAD = 4'd13, CMD_STORE = 4'd14, CMD_NONE = 4'd15
    } t_cmd;

    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_MEM = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_DIV, ST_MEM, ST_WRITE, ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic read_ops;
        logic div_start;
        logic div_step;
        logic mem_read;
        logic commit;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic needs_mem;
        logic div_done;
    } t_stat;
endpackage

// ===== rtl/brm_ctrl.sv =====
// Controller state machine for the byte register machine execute block.
// Depends on brm_pkg.
`timescale 1ns / 1ps
module brm_ctrl
    import brm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_ctrl  o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_READ;
            ST_READ: begin
                if (i_stat.is_div) n_state = ST_DIV;
                else if (i_stat.needs_mem) n_state = ST_MEM;
                else n_state = ST_WRITE;
            end
            ST_DIV:   if (i_stat.div_done) n_state = ST_WRITE;
            ST_MEM:   n_state = ST_WRITE;
            ST_WRITE: n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.capture = i_in_valid;
            end
            ST_READ: begin
                o_ctrl.read_ops  = 1'b1;
                o_ctrl.div_start = i_stat.is_div;
            end
            ST_DIV:   o_ctrl.div_step = 1'b1;
            ST_MEM:   o_ctrl.mem_read = 1'b1;
            ST_WRITE: o_ctrl.commit = 1'b1;
            ST_OUT:   o_out_valid = 1'b1;
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/brm_datapath.sv =====
// Datapath: register file, data memory, ALU, serial divider and flags.
// Depends on brm_pkg.
`timescale 1ns / 1ps
module brm_datapath
    import brm_pkg::*;
#(
    parameter int NUM_REGS  = 7,
    parameter int MEM_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [36:0] i_word,
    output t_stat       o_stat,
    output logic [7:0]  o_result,
    output logic [4:0]  o_flags
);
    localparam int RI_W = (NUM_REGS > 8) ? 3 : ((NUM_REGS > 1) ? $clog2(NUM_REGS) : 1);
    localparam int AW   = $clog2(MEM_BYTES);

    t_cmd        r_cmd;
    logic [2:0]  r_r1, r_r2;
    logic [1:0]  r_mode;
    logic        r_ind;
    logic [7:0]  r_imm;
    logic [15:0] r_inval;
    logic [7:0]  r_a1, r_a2;
    logic [7:0]  r_regs [NUM_REGS];
    logic [7:0]  r_mem  [MEM_BYTES];
    logic [7:0]  r_mem_q;
    logic [NUM_REGS-1:0] r_vld;
    logic [MEM_BYTES-1:0] r_mvld;
    logic        r_ov, r_un, r_ze, r_derr;
    logic [7:0]  r_res;
    logic [7:0]  r_quo, r_rem;
    logic [3:0]  r_dcnt;
    logic [16:0] r_full;

    logic [7:0]  rd1, rd2;
    logic [AW-1:0] mem_a;
    logic [8:0]  trial;
    logic [2:0]  cnt;
    logic [15:0] rol_w, ror_w;
    logic [7:0]  res;
    logic [16:0] full;
    logic        judge, wr_en;
    logic [2:0]  wr_idx;

    function automatic logic [7:0] rd_reg(input logic [2:0] idx,
                                          input logic [7:0] regs [NUM_REGS],
                                          input logic [NUM_REGS-1:0] vld);
        logic [7:0] v;
        v = 8'd0;
        if (32'(idx) < NUM_REGS && vld[idx[RI_W-1:0]])
            v = regs[idx[RI_W-1:0]];
        return v;
    endfunction

    assign rd1 = rd_reg(r_r1, r_regs, r_vld);
    assign rd2 = rd_reg(r_r2, r_regs, r_vld);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd   <= t_cmd'(i_word[3:0]);
            r_r1    <= i_word[6:4];
            r_r2    <= i_word[9:7];
            r_mode  <= i_word[11:10];
            r_ind   <= i_word[12];
            r_imm   <= i_word[20:13];
            r_inval <= i_word[36:21];
        end
        if (i_ctrl.read_ops) begin
            r_a1 <= rd1;
            r_a2 <= rd2;
        end
    end

    assign o_stat.is_div    = (r_cmd == CMD_DIV) && (rd1 != 8'd0);
    assign o_stat.needs_mem = (r_cmd == CMD_LOAD) ||
                              (r_cmd == CMD_MOV && r_mode == SRC_MEM);
    assign o_stat.div_done  = (r_dcnt == 4'd0);

    // restoring divider, one quotient bit per cycle
    assign trial = {r_rem, r_quo[7]} - {1'b0, r_a1};
    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            r_quo  <= rd2;
            r_rem  <= 8'd0;
            r_dcnt <= 4'd8;
        end else if (i_ctrl.div_step && r_dcnt != 4'd0) begin
            if (!trial[8]) begin
                r_rem <= trial[7:0];
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_rem <= {r_rem[6:0], r_quo[7]};
                r_quo <= {r_quo[6:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 4'd1;
        end
    end

    always_comb begin
        mem_a = AW'(r_imm);
        if (r_cmd == CMD_MOV) mem_a = AW'(r_a1);
        else if (r_ind) mem_a = AW'(r_a2);
    end

    // bytes never stored read as zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mem_read) r_mem_q <= r_mvld[mem_a] ? r_mem[mem_a] : 8'd0;
        if (i_ctrl.commit && r_cmd == CMD_STORE) r_mem[mem_a] <= r_a1;
    end

    assign cnt   = r_imm[2:0];
    assign rol_w = {r_a1, r_a1} << cnt;
    assign ror_w = {r_a1, r_a1} >> cnt;

    always_comb begin
        full   = 17'd0;
        judge  = 1'b0;
        wr_en  = 1'b0;
        wr_idx = r_r1;
        res    = 8'd0;
        case (r_cmd)
            CMD_IN: begin
                full = {r_inval[15], r_inval}; judge = 1'b1; wr_en = 1'b1;
            end
            CMD_OUT: full = {9'd0, r_a1};
            CMD_MOV: begin
                wr_en = 1'b1; wr_idx = r_r2;
                if (r_mode == SRC_REG) full = {9'd0, r_a1};
                else if (r_mode == SRC_MEM) full = {9'd0, r_mem_q};
                else full = {9'd0, r_imm};
            end
            CMD_ADD: begin
                full = 17'(r_a2) + 17'(r_a1); judge = 1'b1; wr_en = 1'b1; wr_idx = r_r2;
            end
            CMD_SUB: begin
                full = 17'(r_a2) - 17'(r_a1); judge = 1'b1; wr_en = 1'b1; wr_idx = r_r2;
            end
            CMD_MUL: begin
                full = r_full; judge = 1'b1; wr_en = 1'b1; wr_idx = r_r2;
            end
            CMD_DIV: if (r_a1 != 8'd0) begin
                full = {9'd0, r_quo}; judge = 1'b1; wr_en = 1'b1; wr_idx = r_r2;
            end
            CMD_INC: begin full = 17'(r_a1) + 17'd1; judge = 1'b1; wr_en = 1'b1; end
            CMD_DEC: begin full = 17'(r_a1) - 17'd1; judge = 1'b1; wr_en = 1'b1; end
            CMD_ROL: begin full = {9'd0, rol_w[15:8]}; judge = 1'b1; wr_en = 1'b1; end
            CMD_ROR: begin full = {9'd0, ror_w[7:0]}; judge = 1'b1; wr_en = 1'b1; end
            CMD_SHL: begin full = {9'd0, r_a1 << cnt}; judge = 1'b1; wr_en = 1'b1; end
            CMD_SHR: begin full = {9'd0, r_a1 >> cnt}; judge = 1'b1; wr_en = 1'b1; end
            CMD_LOAD: begin full = {9'd0, r_mem_q}; wr_en = 1'b1; end
            CMD_STORE: full = {9'd0, r_a1};
            default: begin
            end
        endcase
        res = full[7:0];
    end

    // product registered in the read state, ahead of commit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.read_ops) r_full <= 17'(rd2) * 17'(rd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_res  <= res;
            r_derr <= (r_cmd == CMD_DIV) && (r_a1 == 8'd0);
            if (wr_en && 32'(wr_idx) < NUM_REGS)
                r_regs[wr_idx[RI_W-1:0]] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_mvld <= '0;
            r_ov   <= 1'b0;
            r_un   <= 1'b0;
            r_ze   <= 1'b0;
        end else if (i_ctrl.commit) begin
            if (wr_en && 32'(wr_idx) < NUM_REGS)
                r_vld[wr_idx[RI_W-1:0]] <= 1'b1;
            if (r_cmd == CMD_STORE)
                r_mvld[mem_a] <= 1'b1;
            if (judge) begin
                if (!full[16] && full[15:8] != 8'd0) r_ov <= 1'b1;
                if (full[16]) r_un <= 1'b1;
                if (full == 17'd0) r_ze <= 1'b1;
            end
        end
    end

    assign o_result = r_res;
    assign o_flags  = {r_derr, r_ze, r_un, r_ov, r_ov};
endmodule

// ===== rtl/byte_register_machine_execute.sv =====
// One word in, one word out. An accepted word goes through the read state, the
// memory state for LOAD and memory-source MOV (registered memory read) or the
// divide state for DIV with a non-zero divisor (eight-step serial divider), then
// the write and output states. A new word is taken only in idle. Synchronous
// active-low reset clears state, the overflow, underflow and zero flags and the
// register and memory valid bits, so unwritten registers and bytes read zero.
`timescale 1ns / 1ps
`include "byte_register_machine_execute_defines.svh"
module byte_register_machine_execute
    import brm_pkg::*;
#(
    parameter int NUM_REGS  = 7,
    parameter int MEM_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, first_reg, second_reg, source_mode, indirect_address,
    // immediate, input_value, zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value, overflow_flag, carry_flag, underflow_flag, zero_flag,
    // divide_error, zero pad
    output logic [15:0] m_axis_tdata
);
    t_ctrl      ctrl;
    t_stat      stat;
    logic [7:0] result;
    logic [4:0] flags;

    brm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_ctrl(ctrl)
    );

    brm_datapath #(.NUM_REGS(NUM_REGS), .MEM_BYTES(MEM_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl),
        .i_word(s_axis_tdata[36:0]), .o_stat(stat),
        .o_result(result), .o_flags(flags)
    );

    assign m_axis_tdata = {3'd0, flags, result};

    `BRM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `BRM_ASSERT_NEXT(a_div_err_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[12], m_axis_tdata[7:0] == 8'd0 || !m_axis_tvalid)
    `BRM_ASSERT_NEXT(a_sticky_ov, i_clk, i_rst_n, m_axis_tdata[8], m_axis_tdata[8])
endmodule
